### src/vft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vft_pkg;

  localparam int PW = 21;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;

  localparam logic [CFG_IW-1:0] REG_FLOW_GAIN = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DEADBAND = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ALPHA = 3'd2;
  localparam logic [CFG_IW-1:0] REG_LEAK = 3'd3;
  localparam logic [CFG_IW-1:0] REG_PSCALE = 3'd4;

  localparam logic [23:0] FLOW_GAIN_RST = 24'd99096;
  localparam logic [23:0] DEADBAND_RST = 24'd65536;
  localparam logic [16:0] ALPHA_RST = 17'd9830;
  localparam logic [15:0] LEAK_RST = 16'd3277;
  localparam logic [23:0] PSCALE_RST = 24'd171079;

  localparam logic [16:0] ALPHA_ONE = 17'd65536;
  localparam logic [26:0] GAUGE_POS_MAX = 27'd524287;
  localparam logic [26:0] GAUGE_NEG_MAX = 27'd524288;
  // Ceiling of 2^45 / 60, split into two 20-bit halves.
  localparam logic [19:0] RECIP_60_LO = 20'd559241;
  localparam logic [19:0] RECIP_60_HI = 20'd559240;
  localparam logic [5:0] SQRT_STEPS = 6'd26;
  localparam logic [5:0] DIV_STEPS = 6'd4;

  typedef struct packed {
    logic [22:0] dmag;
    logic gneg;
    logic [PW-1:0] excess;
    logic fneg;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [23:0] flow_gain;
    logic [23:0] deadband;
    logic [16:0] alpha;
    logic [15:0] leak;
    logic [23:0] pscale;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_GMUL, S_GAUGE, S_SQRT, S_FMUL, S_RAW, S_AMUL1, S_AMUL2,
    S_FILT, S_VMUL, S_DINIT, S_DIV, S_VOL, S_OUT
  } state_t;

endpackage
`default_nettype wire

### src/vft_front.sv
`timescale 1ns / 1ps
`default_nettype none
module vft_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [119:0] s_tdata,
  output logic q_valid,
  input  wire logic q_ready,
  output vft_pkg::item_t q_data
);

  logic [20:0] inlet, outlet, throat, ambient;
  logic [21:0] sum_io, amb2;
  vft_pkg::item_t item;
  vft_pkg::item_t fifo [2];
  logic wptr, rptr;
  logic [1:0] count;
  logic push, pop;

  assign inlet = s_tdata[20:0];
  assign outlet = s_tdata[41:21];
  assign throat = s_tdata[62:42];
  assign ambient = s_tdata[83:63];
  assign sum_io = {1'b0, inlet} + {1'b0, outlet};
  assign amb2 = {ambient, 1'b0};

  always_comb begin
    item.now = s_tdata[115:84];
    item.gneg = sum_io < amb2;
    item.dmag = item.gneg ? {1'b0, amb2 - sum_io} : {1'b0, sum_io - amb2};
    item.excess = '0;
    item.fneg = 1'b0;
    if (inlet > outlet && inlet > throat) begin
      item.excess = inlet - throat;
    end else if (outlet > inlet && outlet > throat) begin
      item.excess = outlet - throat;
      item.fneg = 1'b1;
    end
  end

  assign s_tready = count != 2'd2;
  assign push = s_tvalid && s_tready;
  assign q_valid = count != 2'd0;
  assign pop = q_valid && q_ready;
  assign q_data = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= item;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### src/vft_back.sv
`timescale 1ns / 1ps
`default_nettype none
module vft_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire vft_pkg::cfg_t cfg,
  input  wire logic q_valid,
  output logic q_ready,
  input  wire vft_pkg::item_t q_data,
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [87:0] m_tdata
);

  vft_pkg::state_t state, state_next;
  vft_pkg::item_t it;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b;
  logic [19:0] gauge;
  logic [53:0] rad;
  logic [29:0] srem;
  logic [26:0] root;
  logic [5:0] cnt;
  logic [30:0] rmag;
  logic signed [49:0] acc;
  logic [31:0] filt, vol, last_time;
  logic [38:0] num;
  logic [79:0] qacc, qadd;
  logic [33:0] quot;
  logic dsat;
  logic [16:0] alpha_c, alpha_inv;
  logic [31:0] fmag;
  logic [26:0] gq;
  logic [29:0] s_trial, s_rem;
  logic [45:0] rq;
  logic signed [49:0] sum;
  logic [48:0] amag;
  logic [32:0] fq;
  logic [31:0] filt_new;
  logic [63:0] num_full;
  logic [33:0] term;
  logic signed [37:0] v;

  assign alpha_c = cfg.alpha > vft_pkg::ALPHA_ONE ? vft_pkg::ALPHA_ONE : cfg.alpha;
  assign alpha_inv = vft_pkg::ALPHA_ONE - alpha_c;
  assign fmag = filt[31] ? 32'(-filt) : filt;
  assign q_ready = state == vft_pkg::S_IDLE;
  assign quot = qacc[78:45];

  always_comb begin
    case (state)
      vft_pkg::S_GMUL: begin
        mul_a = {9'd0, it.dmag};
        mul_b = {8'd0, cfg.pscale};
      end
      vft_pkg::S_FMUL: begin
        mul_a = {5'd0, root};
        mul_b = {8'd0, cfg.flow_gain};
      end
      vft_pkg::S_AMUL1: begin
        mul_a = {1'b0, rmag};
        mul_b = {15'd0, alpha_c};
      end
      vft_pkg::S_AMUL2: begin
        mul_a = fmag;
        mul_b = {15'd0, alpha_inv};
      end
      vft_pkg::S_VMUL: begin
        mul_a = fmag;
        mul_b = it.now - last_time;
      end
      vft_pkg::S_DIV: begin
        mul_a = cnt >= 6'd3 ? {12'd0, num[19:0]} : {13'd0, num[38:20]};
        mul_b = (cnt == 6'd4 || cnt == 6'd2) ? {12'd0, vft_pkg::RECIP_60_LO}
                                             : {12'd0, vft_pkg::RECIP_60_HI};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    gq = 27'((prod[46:0] + 47'd1048576) >> 21);
    s_rem = {srem[27:0], rad[53:52]};
    s_trial = {1'b0, root, 2'b01};
    qadd = cnt == 6'd0 ? {prod[39:0], 40'd0}
         : (cnt == 6'd1 || cnt == 6'd2) ? {20'd0, prod[39:0], 20'd0}
         : {40'd0, prod[39:0]};
    rq = 46'((prod[50:0] + 51'd131072) >> 18);
    sum = acc + (filt[31] ? -$signed({2'b0, prod[47:0]}) : $signed({2'b0, prod[47:0]}));
    amag = sum[49] ? 49'(-sum) : 49'(sum);
    fq = 33'((amag + 49'd32768) >> 16);
    if (sum[49]) begin
      filt_new = fq > 33'h080000000 ? 32'h80000000 : 32'(-fq);
    end else begin
      filt_new = fq > 33'h07fffffff ? 32'h7fffffff : fq[31:0];
    end
    num_full = prod + 64'd30;
    term = dsat ? '1 : quot;
    v = $signed({6'd0, vol}) - $signed({22'd0, cfg.leak})
        + (filt[31] ? -$signed({4'd0, term}) : $signed({4'd0, term}));
  end

  always_comb begin
    state_next = state;
    case (state)
      vft_pkg::S_IDLE: if (q_valid) state_next = vft_pkg::S_GMUL;
      vft_pkg::S_GMUL: state_next = vft_pkg::S_GAUGE;
      vft_pkg::S_GAUGE: state_next = vft_pkg::S_SQRT;
      vft_pkg::S_SQRT: if (cnt == 6'd0) state_next = vft_pkg::S_FMUL;
      vft_pkg::S_FMUL: state_next = vft_pkg::S_RAW;
      vft_pkg::S_RAW: state_next = vft_pkg::S_AMUL1;
      vft_pkg::S_AMUL1: state_next = vft_pkg::S_AMUL2;
      vft_pkg::S_AMUL2: state_next = vft_pkg::S_FILT;
      vft_pkg::S_FILT: begin
        state_next = last_time != 32'd0 ? vft_pkg::S_VMUL : vft_pkg::S_OUT;
      end
      vft_pkg::S_VMUL: state_next = vft_pkg::S_DINIT;
      vft_pkg::S_DINIT: state_next = vft_pkg::S_DIV;
      vft_pkg::S_DIV: if (cnt == 6'd0) state_next = vft_pkg::S_VOL;
      vft_pkg::S_VOL: state_next = vft_pkg::S_OUT;
      vft_pkg::S_OUT: if (!m_tvalid || m_tready) state_next = vft_pkg::S_IDLE;
      default: state_next = vft_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vft_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      filt <= '0;
      vol <= '0;
      last_time <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        vft_pkg::S_IDLE: begin
          it <= q_data;
          rad <= {1'b0, q_data.excess, 32'd0};
          srem <= '0;
          root <= '0;
          cnt <= vft_pkg::SQRT_STEPS;
        end
        vft_pkg::S_GAUGE: begin
          if (it.gneg) begin
            gauge <= 20'(-(gq > vft_pkg::GAUGE_NEG_MAX ? vft_pkg::GAUGE_NEG_MAX : gq));
          end else begin
            gauge <= 20'(gq > vft_pkg::GAUGE_POS_MAX ? vft_pkg::GAUGE_POS_MAX : gq);
          end
        end
        vft_pkg::S_SQRT: begin
          rad <= {rad[51:0], 2'b00};
          cnt <= cnt - 6'd1;
          if (s_rem >= s_trial) begin
            srem <= s_rem - s_trial;
            root <= {root[25:0], 1'b1};
          end else begin
            srem <= s_rem;
            root <= {root[25:0], 1'b0};
          end
        end
        vft_pkg::S_RAW: begin
          if (rq > 46'h7fffffff) begin
            rmag <= '1;
          end else if (rq < {22'd0, cfg.deadband}) begin
            rmag <= '0;
          end else begin
            rmag <= rq[30:0];
          end
        end
        vft_pkg::S_AMUL2: begin
          acc <= it.fneg ? -$signed({2'b0, prod[47:0]}) : $signed({2'b0, prod[47:0]});
        end
        vft_pkg::S_FILT: filt <= filt_new;
        vft_pkg::S_DINIT: begin
          dsat <= |num_full[63:39];
          num <= num_full[38:0];
          qacc <= '0;
          cnt <= vft_pkg::DIV_STEPS;
        end
        vft_pkg::S_DIV: begin
          qacc <= qacc + qadd;
          cnt <= cnt - 6'd1;
        end
        vft_pkg::S_VOL: begin
          if (v < 0) begin
            vol <= '0;
          end else if (v > 38'sh0ffffffff) begin
            vol <= '1;
          end else begin
            vol <= v[31:0];
          end
        end
        vft_pkg::S_OUT: begin
          if (!m_tvalid || m_tready) begin
            last_time <= it.now;
            m_tdata <= {4'd0, vol, filt, gauge};
          end
        end
        default: begin
        end
      endcase
      if (state == vft_pkg::S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### src/venturi_flow_tidal_volume.sv
// One result word follows each accepted input word; volume is integrated only when the
// last timestamp is nonzero. A 27-step square root and a four-part reciprocal multiply for
// the divide by 60 share one sequencer and one 32 by 32 multiplier; the sequencer handles
// one word at a time, and a two-word queue lets the input side take words while it is busy.
// Synchronous reset restores default registers and clears flow, volume and last time.
`timescale 1ns / 1ps
`default_nettype none
module venturi_flow_tidal_volume (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  // inlet_pressure, outlet_pressure, neck_pressure, room_pressure, timestamp_ms
  input  wire logic [119:0] s_tdata,
  output logic m_tvalid,
  input  wire logic m_tready,
  // gauge_pressure, smoothed_flow, tidal_volume
  output logic [87:0] m_tdata,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [vft_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [vft_pkg::CFG_DW-1:0] cfg_data
);

  vft_pkg::cfg_t cfg;
  vft_pkg::item_t q_data;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flow_gain <= vft_pkg::FLOW_GAIN_RST;
      cfg.deadband <= vft_pkg::DEADBAND_RST;
      cfg.alpha <= vft_pkg::ALPHA_RST;
      cfg.leak <= vft_pkg::LEAK_RST;
      cfg.pscale <= vft_pkg::PSCALE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        vft_pkg::REG_FLOW_GAIN: cfg.flow_gain <= cfg_data;
        vft_pkg::REG_DEADBAND: cfg.deadband <= cfg_data;
        vft_pkg::REG_ALPHA: cfg.alpha <= cfg_data[16:0];
        vft_pkg::REG_LEAK: cfg.leak <= cfg_data[15:0];
        vft_pkg::REG_PSCALE: cfg.pscale <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  vft_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  vft_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule
`default_nettype wire

### tb/sv/venturi_flow_tidal_volume_test.sv
`timescale 1ns / 1ps
module venturi_flow_tidal_volume_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [vft_pkg::CFG_IW-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [20:0] inlet;
    logic [20:0] outlet;
    logic [20:0] throat;
    logic [20:0] ambient;
    logic [31:0] stamp;
  } sample_t;

  typedef struct packed {
    logic [19:0] gauge;
    logic [31:0] flow;
    logic [31:0] volume;
  } reading_t;

  typedef struct {
    sample_t smp;
    bit known;
    reading_t want;
  } vector_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [119:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [87:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [vft_pkg::CFG_IW-1:0] cfg_index;
  logic [vft_pkg::CFG_DW-1:0] cfg_data;

  venturi_flow_tidal_volume u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [23:0] gain_q, deadband_q, pscale_q;
  logic [16:0] alpha_q;
  logic [15:0] leak_q;
  logic signed [31:0] flow_q;
  logic [31:0] volume_q, prev_stamp_q;

  reading_t readings_due[$];
  int mismatches;
  int idle_cycles;
  bit timed_out;
  bit calm;
  bit hold_off;
  bit sending;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic reading_t meter_sample(input sample_t s);
    reading_t o;
    longint sio, a2, dm, gq, ex, rm, raw, al, acc, am, q, filt, fm, term, v;
    logic [31:0] dt;
    bit gn, fn;
    sio = s.inlet + s.outlet;
    a2 = 2 * s.ambient;
    gn = sio < a2;
    dm = gn ? a2 - sio : sio - a2;
    gq = (dm * pscale_q + (64'd1 << 20)) >>> 21;
    if (gn) begin
      if (gq > 524288) gq = 524288;
      o.gauge = 20'(-gq);
    end else begin
      if (gq > 524287) gq = 524287;
      o.gauge = 20'(gq);
    end
    ex = 0;
    fn = 0;
    if (s.inlet > s.outlet && s.inlet > s.throat) begin
      ex = s.inlet - s.throat;
    end else if (s.outlet > s.inlet && s.outlet > s.throat) begin
      ex = s.outlet - s.throat;
      fn = 1;
    end
    rm = 0;
    if (ex != 0) begin
      rm = (longint'(gain_q) * longint'(isqrt(64'(ex) << 32)) + (64'd1 << 17)) >>> 18;
      if (rm > 64'd2147483647) rm = 64'd2147483647;
    end
    if (rm < deadband_q) rm = 0;
    raw = fn ? -rm : rm;
    al = alpha_q > vft_pkg::ALPHA_ONE ? 65536 : alpha_q;
    acc = raw * al + longint'(flow_q) * (65536 - al);
    am = acc < 0 ? -acc : acc;
    q = (am + 32768) >>> 16;
    filt = acc < 0 ? -q : q;
    if (filt > 64'sd2147483647) filt = 64'sd2147483647;
    if (filt < -64'sd2147483648) filt = -64'sd2147483648;
    flow_q = 32'(filt);
    if (prev_stamp_q != 0) begin
      dt = s.stamp - prev_stamp_q;
      fm = filt < 0 ? -filt : filt;
      term = (fm * longint'(dt) + 30) / 60;
      if (filt < 0) term = -term;
      v = longint'(volume_q) + term - longint'(leak_q);
      if (v < 0) v = 0;
      if (v > 64'sd4294967295) v = 64'sd4294967295;
      volume_q = 32'(v);
    end
    prev_stamp_q = s.stamp;
    o.flow = flow_q;
    o.volume = volume_q;
    return o;
  endfunction

  task automatic clear_meter();
    gain_q = vft_pkg::FLOW_GAIN_RST;
    deadband_q = vft_pkg::DEADBAND_RST;
    alpha_q = vft_pkg::ALPHA_RST;
    leak_q = vft_pkg::LEAK_RST;
    pscale_q = vft_pkg::PSCALE_RST;
    flow_q = 0;
    volume_q = 0;
    prev_stamp_q = 0;
  endtask

  task automatic write_reg(input logic [vft_pkg::CFG_IW-1:0] idx,
                           input logic [vft_pkg::CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      vft_pkg::REG_FLOW_GAIN: gain_q = val;
      vft_pkg::REG_DEADBAND: deadband_q = val;
      vft_pkg::REG_ALPHA: alpha_q = val[16:0];
      vft_pkg::REG_LEAK: leak_q = val[15:0];
      vft_pkg::REG_PSCALE: pscale_q = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    while (readings_due.size() != 0 && !timed_out) @(posedge clk);
    while (n < DRAIN_CYCLES) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic send_sample(input sample_t s, input bit known, input reading_t want);
    reading_t got;
    while (!calm && !hold_off && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {8'd0, s.stamp, s.ambient, s.throat, s.outlet, s.inlet};
    got = meter_sample(s);
    if (known && got != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row disagrees with predictor: row %h %h %h predictor %h %h %h",
                 want.gauge, want.flow, want.volume, got.gauge, got.flow, got.volume);
    end
    readings_due.push_back(got);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic sample_t random_sample(input logic [31:0] stamp);
    sample_t s;
    int mode;
    mode = $urandom_range(9);
    s.ambient = (mode == 0) ? 21'($urandom) : 21'd1620000 + 21'($urandom_range(4000));
    s.throat = (mode == 1) ? 21'($urandom) : s.ambient + 21'($urandom_range(3000));
    s.inlet = (mode == 2) ? 21'($urandom) : s.throat + 21'($urandom_range(40000));
    s.outlet = (mode == 3) ? 21'($urandom) : s.throat + 21'($urandom_range(40000));
    if (mode == 4) s.outlet = s.inlet;
    s.stamp = (mode == 5) ? $urandom : ((mode == 6) ? 32'd0 : stamp);
    return s;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !hold_off && (calm || $urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    reading_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.gauge = m_tdata[19:0];
      got.flow = m_tdata[51:20];
      got.volume = m_tdata[83:52];
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_tdata);
      end else begin
        want = readings_due.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected gauge %h flow %h volume %h, got %h %h %h",
                     want.gauge, want.flow, want.volume, got.gauge, got.flow,
                     got.volume);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      timed_out = 1'b1;
      $display("venturi_flow_tidal_volume test failed");
      $finish;
    end
  end

  initial begin
    int n;
    @(posedge clk);
    wait (sending);
    while (sending) begin
      n = 0;
      while (n < 600) begin
        @(posedge clk);
        n++;
      end
      hold_off = 1'b1;
      n = 0;
      while (n < 400) begin
        @(posedge clk);
        n++;
      end
      hold_off = 1'b0;
      n = 0;
      while (n < 20000) begin
        @(posedge clk);
        n++;
      end
    end
  end

  initial begin
    vector_t vectors[$];
    vector_t vec;
    sample_t s;
    reading_t w;
    logic [31:0] stamp;
    int phase, i;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    calm = 1'b0;
    hold_off = 1'b0;
    sending = 1'b0;
    clear_meter();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // All zeros after reset: no flow, no volume on the first sample.
    vec.smp = '{0, 0, 0, 0, 0};
    vec.known = 1;
    vec.want = '{0, 0, 0};
    vectors.push_back(vec);
    vec.known = 0;
    vec.smp = '{21'h1FFFFF, 21'h1FFFFF, 0, 0, 32'd1000};
    vectors.push_back(vec);
    vec.smp = '{0, 0, 0, 21'h1FFFFF, 32'd1010};
    vectors.push_back(vec);
    vec.smp = '{21'h1FFFFF, 0, 0, 0, 32'd1020};
    vectors.push_back(vec);
    vec.smp = '{0, 21'h1FFFFF, 0, 0, 32'd1030};
    vectors.push_back(vec);
    vec.smp = '{21'd1000, 21'd1000, 21'd500, 21'd500, 32'd1040};
    vectors.push_back(vec);
    vec.smp = '{21'd500, 21'd400, 21'd900, 21'd500, 32'd1050};
    vectors.push_back(vec);
    vec.smp = '{21'd1640000, 21'd1620000, 21'd1620001, 21'd1620000, 32'd0};
    vectors.push_back(vec);
    vec.smp = '{21'd1620000, 21'd1650000, 21'd1620000, 21'd1620000, 32'd5};
    vectors.push_back(vec);
    vec.smp = '{21'd1650000, 21'd1620000, 21'd1620000, 21'd1620000, 32'hFFFFFFF0};
    vectors.push_back(vec);
    vec.smp = '{21'd1650000, 21'd1620000, 21'd1620000, 21'd1620000, 32'd20};
    vectors.push_back(vec);
    vec.smp = '{21'd1620002, 21'd1620000, 21'd1620000, 21'd1620000, 32'd30};
    vectors.push_back(vec);
    vec.smp = '{21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 32'hFFFFFFFF};
    vectors.push_back(vec);
    vec.smp = '{21'h0AAAAA, 21'h155555, 21'h0AAAAA, 21'h155555, 32'hAAAAAAAA};
    vectors.push_back(vec);
    vec.smp = '{21'h155555, 21'h0AAAAA, 21'h155555, 21'h0AAAAA, 32'h55555555};
    vectors.push_back(vec);
    for (i = 0; i < vectors.size(); i++) send_sample(vectors[i].smp, vectors[i].known,
                                                      vectors[i].want);
    s_tvalid <= 1'b0;
    wait_idle();

    stamp = 32'd100;
    sending = 1'b1;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          write_reg(vft_pkg::REG_FLOW_GAIN, 24'hFFFFFF);
          write_reg(vft_pkg::REG_DEADBAND, 24'd0);
          write_reg(vft_pkg::REG_ALPHA, 24'd65536);
          write_reg(vft_pkg::REG_LEAK, 24'hFFFF);
          write_reg(vft_pkg::REG_PSCALE, 24'hFFFFFF);
        end
        2: begin
          write_reg(vft_pkg::REG_FLOW_GAIN, 24'd0);
          write_reg(vft_pkg::REG_DEADBAND, 24'hFFFFFF);
          write_reg(vft_pkg::REG_ALPHA, 24'd0);
          write_reg(vft_pkg::REG_LEAK, 24'd0);
          write_reg(vft_pkg::REG_PSCALE, 24'd0);
        end
        3: begin
          write_reg(vft_pkg::REG_FLOW_GAIN, 24'd99096);
          write_reg(vft_pkg::REG_DEADBAND, 24'd1000);
          write_reg(vft_pkg::REG_ALPHA, 24'h1FFFF);
          write_reg(vft_pkg::REG_LEAK, 24'd10);
          write_reg(REG_UNUSED, 24'h123456);
        end
        4, 5: begin
          write_reg(vft_pkg::REG_FLOW_GAIN, 24'($urandom));
          write_reg(vft_pkg::REG_DEADBAND, 24'($urandom_range(200000)));
          write_reg(vft_pkg::REG_ALPHA, 24'($urandom_range(70000)));
          write_reg(vft_pkg::REG_LEAK, 24'($urandom));
          write_reg(vft_pkg::REG_PSCALE, 24'($urandom));
        end
        default: ;
      endcase
      cfg_valid <= 1'b0;
      calm = (phase == 3);
      for (i = 0; i < 310; i++) begin
        stamp = stamp + 32'($urandom_range(1, 40));
        s = random_sample(stamp);
        send_sample(s, 0, w);
      end
      s_tvalid <= 1'b0;
      wait_idle();
    end
    sending = 1'b0;
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("venturi_flow_tidal_volume test passed");
    end else begin
      $display("venturi_flow_tidal_volume test failed");
    end
    $finish;
  end

endmodule
